/* design/qpe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_pkg
// Shared types, character codes and helper functions for the quoted-printable
// encoder.
// ----------------------------------------------------------------------------
package qpe_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_EQ        = 8'h3D;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_SP        = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_A         = 8'h41;
  localparam logic [7:0] CH_D         = 8'h44;
  localparam logic [7:0] CH_PRINT_MIN = 8'd32;
  localparam logic [7:0] CH_PRINT_MAX = 8'd126;
  localparam logic [7:0] LIMIT_RESET  = 8'd73;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } qpe_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
  } qpe_out_t;

  // body of one encoded byte
  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_HEX,
    KIND_CRLF,
    KIND_EQ0D
  } qpe_kind_t;

  typedef struct packed {
    logic       soft_brk;
    qpe_kind_t  kind;
    logic [7:0] ch;
    logic       run_last;
    logic       message_end;
  } qpe_job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = CH_ZERO + {4'd0, n};
    end else begin
      r = CH_A + {4'd0, n} - 8'd10;
    end
    return r;
  endfunction

  function automatic logic [2:0] job_len(input qpe_job_t job);
    logic [2:0] body;
    unique case (job.kind)
      KIND_PLAIN: body = 3'd1;
      KIND_HEX:   body = 3'd3;
      KIND_CRLF:  body = 3'd2;
      KIND_EQ0D:  body = 3'd3;
    endcase
    return job.soft_brk ? body + 3'd3 : body;
  endfunction

  function automatic logic [7:0] job_char(input qpe_job_t job, input logic [2:0] idx);
    logic [2:0] p;
    logic [7:0] r;
    p = job.soft_brk ? idx - 3'd3 : idx;
    if (job.soft_brk && idx < 3'd3) begin
      // soft line break "=" CR LF
      r = (idx == 3'd0) ? CH_EQ : ((idx == 3'd1) ? CH_CR : CH_LF);
    end else begin
      unique case (job.kind)
        KIND_PLAIN: r = job.ch;
        KIND_HEX:   r = (p == 3'd0) ? CH_EQ :
                        ((p == 3'd1) ? hex_char(job.ch[7:4]) : hex_char(job.ch[3:0]));
        KIND_CRLF:  r = (p == 3'd0) ? CH_CR : CH_LF;
        KIND_EQ0D:  r = (p == 3'd0) ? CH_EQ : ((p == 3'd1) ? CH_ZERO : CH_D);
      endcase
    end
    return r;
  endfunction

endpackage

/* design/qpe_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_front
// Accepts message bytes, keeps the lookahead byte and the line count, and
// turns each transaction into zero, one or two encode jobs.
// ----------------------------------------------------------------------------
module qpe_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      limit,
  input  logic            in_valid,
  output logic            in_ready,
  input  qpe_pkg::qpe_in_t  in_data,
  input  logic            q_full,
  output logic            q_push,
  output qpe_pkg::qpe_job_t q_data
);
  import qpe_pkg::*;

  typedef struct packed {
    qpe_job_t   job;
    logic [7:0] count;
    logic       consumed;
  } enc_t;

  function automatic enc_t encode(input logic [7:0] c, input logic at_end,
                                  input logic [7:0] nxt, input logic [7:0] count,
                                  input logic [7:0] lim);
    enc_t       e;
    logic [7:0] c0;
    logic [8:0] sum;
    logic       eol;
    e = '0;
    e.job.ch = c;
    e.job.soft_brk = (count >= lim);
    c0 = e.job.soft_brk ? 8'd0 : count;
    eol = at_end || nxt == CH_CR || nxt == CH_LF;
    if (c == CH_CR) begin
      e.consumed = !at_end && nxt == CH_LF;
      e.job.kind = e.consumed ? KIND_CRLF : KIND_EQ0D;
      e.count = 8'd0;
    end else if (c == CH_LF) begin
      e.job.kind = KIND_CRLF;
      e.count = 8'd0;
    end else begin
      if (c == CH_EQ || c < CH_PRINT_MIN || c > CH_PRINT_MAX ||
          ((c == CH_SP || c == CH_TAB) && eol)) begin
        e.job.kind = KIND_HEX;
        sum = {1'b0, c0} + 9'd3;
      end else begin
        e.job.kind = KIND_PLAIN;
        sum = {1'b0, c0} + 9'd1;
      end
      e.count = sum[8] ? 8'hFF : sum[7:0];
    end
    return e;
  endfunction

  logic [7:0] held_byte;
  logic       held_valid;
  logic       skip_linefeed;
  logic [7:0] line_count;
  logic       pend_valid;
  qpe_job_t   pend;

  enc_t       enc1, enc2;
  logic       do1, do2, cons, accept;
  logic [7:0] cnt_mid;
  qpe_job_t   job1, job2;

  always_comb begin
    enc1 = encode(held_byte, 1'b0, in_data.in_byte, line_count, limit);
    do1 = held_valid && !skip_linefeed;
    cnt_mid = do1 ? enc1.count : line_count;
    cons = do1 && enc1.consumed;
    enc2 = encode(in_data.in_byte, 1'b1, 8'h00, cnt_mid, limit);
    do2 = in_data.in_last && !cons;

    job1 = enc1.job;
    job1.run_last = !do2;
    job1.message_end = in_data.in_last && !do2;
    job2 = enc2.job;
    job2.run_last = 1'b1;
    job2.message_end = 1'b1;

    in_ready = !pend_valid && !q_full;
    accept = in_valid && in_ready;
    q_push = !q_full && (pend_valid || (in_valid && (do1 || do2)));
    q_data = pend_valid ? pend : (do1 ? job1 : job2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte <= '0;
      held_valid <= 1'b0;
      skip_linefeed <= 1'b0;
      line_count <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (in_data.in_last) begin
          held_byte <= '0;
          held_valid <= 1'b0;
          skip_linefeed <= 1'b0;
          line_count <= '0;
        end else begin
          held_byte <= in_data.in_byte;
          held_valid <= 1'b1;
          skip_linefeed <= cons;
          line_count <= cnt_mid;
        end
        // second job of a step is held in pend until the queue can take it
        if (do1 && do2) begin
          pend_valid <= 1'b1;
        end
      end else if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do1 && do2) begin
      pend <= job2;
    end
  end

endmodule

/* design/qpe_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_queue
// Short FIFO of encode jobs between the front and back ends.
// ----------------------------------------------------------------------------
module qpe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  qpe_pkg::qpe_job_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output qpe_pkg::qpe_job_t head
);
  import qpe_pkg::*;

  qpe_job_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;

  assign full  = (cnt == QCNT_W'(QDEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= QCNT_W'(QDEPTH)) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty)) else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == cnt[QPTR_W-1:0]) else $error("queue pointers disagree with count");

endmodule

/* design/qpe_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpe_back
// Expands the job at the head of the queue into output characters, one per
// cycle while a job is queued and the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module qpe_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  qpe_pkg::qpe_job_t head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output qpe_pkg::qpe_out_t out_data
);
  import qpe_pkg::*;

  logic [2:0] idx;
  logic [2:0] len;
  logic       last_char;
  logic       load;

  always_comb begin
    len = job_len(head);
    last_char = (idx == len - 3'd1);
    load = !q_empty && (!out_valid || out_ready);
    q_pop = load && last_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= last_char ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte <= job_char(head, idx);
      out_data.run_last <= last_char && head.run_last;
      out_data.message_end <= last_char && head.message_end;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> idx < len) else $error("character index past end of job");

endmodule

/* design/quoted_printable_encoder.sv */
`timescale 1ns / 1ps
// Flow: a byte's job is queued by the transaction that supplies its lookahead
//   (the next byte), or by its own if marked last; the output stage is registered.
// Throughput: one output character per cycle while jobs are queued and out_ready
//   holds; a job gives 1 to 6 characters on the single-character output port, a last byte up to two jobs.
// Reset: synchronous; clears lookahead, line count, queue and output stage,
//   and sets soft_break_limit to 73.
// ----------------------------------------------------------------------------
// quoted_printable_encoder
// Quoted-printable encoder: front end classifies bytes, a job queue decouples
// it from the back end that emits characters.
// ----------------------------------------------------------------------------
module quoted_printable_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  qpe_pkg::qpe_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qpe_pkg::qpe_out_t out_data
);
  import qpe_pkg::*;

  logic [7:0] soft_break_limit;
  logic       q_full, q_push, q_pop, q_empty;
  qpe_job_t   q_wdata, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_break_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      soft_break_limit <= cfg_wr_data;
    end
  end

  qpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .limit    (soft_break_limit),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  qpe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  qpe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
